// File: hdl/tga_pkg.sv
package tga_pkg;

  localparam int PIXEL_COUNT_BITS_DEF = 24;
  localparam int PIXEL_COUNT_W        = 25;
  localparam int APB_DATA_W           = 32;
  localparam int APB_ADDR_W           = 4;

  localparam logic [1:0] FMT_GRAY = 2'd0;
  localparam logic [1:0] FMT_BGR  = 2'd1;
  localparam logic [1:0] FMT_BGRA = 2'd2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    REG_RLE_ENABLE   = 2'd0,
    REG_PIXEL_FORMAT = 2'd1,
    REG_PIXEL_COUNT  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic                     rle_enable;
    logic [1:0]               pixel_format;
    logic [PIXEL_COUNT_W-1:0] pixel_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red_or_gray;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       last_pixel;
    logic       format_error;
  } pixel_t;

endpackage

// File: hdl/tga_byte_if.sv
interface tga_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// File: hdl/tga_pixel_if.sv
interface tga_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_or_gray;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] repeat_count;
  logic       last_pixel;
  logic       format_error;

  modport source (
    output valid, output red_or_gray, output green, output blue, output alpha,
    output repeat_count, output last_pixel, output format_error, input ready
  );
  modport sink (
    input valid, input red_or_gray, input green, input blue, input alpha,
    input repeat_count, input last_pixel, input format_error, output ready
  );
endinterface

// File: hdl/tga_rle_pixel_decoder.sv
// A byte is registered when it is accepted and is decoded into the result register
// when that register is free or being read, so a pixel leaves through both registers.
// One byte is accepted in every cycle while the pixel output is not stalled; the
// decode state is updated once per byte. The asynchronous active-low reset empties
// both registers, restores the register defaults and arms the decoder to expect a
// packet header; a write to any of the three registers re-arms the decoder the same way.
module tga_rle_pixel_decoder
  import tga_pkg::*;
#(
  parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  tga_byte_if.sink              byte_i,
  tga_pixel_if.source           pixel_o
);

  cfg_t       cfg;
  logic       restart;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       res_valid;
  pixel_t     res;
  logic       out_valid_q;
  pixel_t     out_q;

  assign pready = 1'b1;

  tga_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  assign advance      = in_valid_q & (~out_valid_q | pixel_o.ready);
  assign byte_i.ready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
    end
  end

  tga_decode #(
    .PixelCountBits (PIXEL_COUNT_BITS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .restart_i   (restart),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (pixel_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign pixel_o.valid        = out_valid_q;
  assign pixel_o.red_or_gray  = out_q.red_or_gray;
  assign pixel_o.green        = out_q.green;
  assign pixel_o.blue         = out_q.blue;
  assign pixel_o.alpha        = out_q.alpha;
  assign pixel_o.repeat_count = out_q.repeat_count;
  assign pixel_o.last_pixel   = out_q.last_pixel;
  assign pixel_o.format_error = out_q.format_error;

endmodule

// File: hdl/tga_apb_regs.sv
module tga_apb_regs
  import tga_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output logic [APB_DATA_W-1:0] prdata_o,
  output cfg_t                  cfg_o,
  output logic                  restart_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign wr_en = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rle_enable   <= 1'b0;
      cfg_q.pixel_format <= FMT_BGR;
      cfg_q.pixel_count  <= PIXEL_COUNT_W'(1);
    end else if (wr_en) begin
      case (paddr_i[3:2])
        REG_RLE_ENABLE:   cfg_q.rle_enable   <= pwdata_i[0];
        REG_PIXEL_FORMAT: cfg_q.pixel_format <= pwdata_i[1:0];
        REG_PIXEL_COUNT:  cfg_q.pixel_count  <= pwdata_i[PIXEL_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    restart_o = 1'b0;
    if (wr_en) begin
      case (paddr_i[3:2])
        REG_RLE_ENABLE, REG_PIXEL_FORMAT, REG_PIXEL_COUNT: restart_o = 1'b1;
        default: restart_o = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[3:2])
      REG_RLE_ENABLE:   prdata_o = APB_DATA_W'(cfg_q.rle_enable);
      REG_PIXEL_FORMAT: prdata_o = APB_DATA_W'(cfg_q.pixel_format);
      REG_PIXEL_COUNT:  prdata_o = APB_DATA_W'(cfg_q.pixel_count);
      default:          prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/tga_decode.sv
module tga_decode
  import tga_pkg::*;
#(
  parameter int PixelCountBits = PIXEL_COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       restart_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output pixel_t     res_o
);

  localparam int CntW = PixelCountBits + 1;
  localparam int ExtW = (CntW > PIXEL_COUNT_W) ? CntW : PIXEL_COUNT_W;

  logic            hdr_q, hdr_d;
  logic            rep_q, rep_d;
  logic [7:0]      rr_q, rr_d;
  logic [1:0]      idx_q, idx_d;
  logic [23:0]     held_q, held_d;
  logic [CntW-1:0] emitted_q, emitted_d;

  logic [ExtW-1:0] pc_ext;
  logic [CntW-1:0] pc_m;
  logic [CntW-1:0] top_val;
  logic [CntW-1:0] img_size;
  logic [CntW-1:0] left;
  logic [CntW-1:0] emitted_sum;
  logic [7:0]      hdr_len;
  logic [7:0]      hdr_len_c;
  logic [7:0]      rr_eff;
  logic [7:0]      cnt;
  logic [1:0]      final_idx;
  logic            is_gray;
  logic            is_bgr;
  logic            complete;
  logic            last;

  always_comb begin
    pc_ext   = ExtW'(cfg_i.pixel_count);
    pc_m     = pc_ext[CntW-1:0];
    top_val  = CntW'(1) << PixelCountBits;
    if (pc_m == '0) begin
      img_size = CntW'(1);
    end else if (pc_m > top_val) begin
      img_size = top_val;
    end else begin
      img_size = pc_m;
    end
    left = (img_size > emitted_q) ? (img_size - emitted_q) : CntW'(1);
    hdr_len = {1'b0, byte_i[6:0]} + 8'd1;
    hdr_len_c = (CntW'(hdr_len) > left) ? left[7:0] : hdr_len;
  end

  always_comb begin
    is_gray   = (cfg_i.pixel_format == FMT_GRAY);
    is_bgr    = (cfg_i.pixel_format == FMT_BGR);
    final_idx = is_bgr ? 2'd2 : 2'd3;

    hdr_d       = hdr_q;
    rep_d       = rep_q;
    rr_d        = rr_q;
    idx_d       = idx_q;
    held_d      = held_q;
    emitted_d   = emitted_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    complete    = 1'b0;
    rr_eff      = 8'd1;
    cnt         = 8'd1;
    emitted_sum = emitted_q;
    last        = 1'b0;

    if (cfg_i.rle_enable && is_gray) begin
      res_valid_o        = 1'b1;
      res_o.format_error = 1'b1;
    end else if (cfg_i.rle_enable && hdr_q) begin
      rep_d = byte_i[7];
      rr_d  = hdr_len_c;
      hdr_d = 1'b0;
      idx_d = 2'd0;
    end else begin
      if (is_gray) begin
        res_o.red_or_gray = byte_i;
        idx_d             = 2'd0;
        complete          = 1'b1;
      end else if (idx_q >= final_idx) begin
        res_o.blue  = held_q[7:0];
        res_o.green = held_q[15:8];
        if (is_bgr) begin
          res_o.red_or_gray = byte_i;
          res_o.alpha       = ALPHA_OPAQUE;
        end else begin
          res_o.red_or_gray = held_q[23:16];
          res_o.alpha       = byte_i;
        end
        idx_d    = 2'd0;
        complete = 1'b1;
      end else begin
        case (idx_q)
          2'd0:    held_d[7:0]   = byte_i;
          2'd1:    held_d[15:8]  = byte_i;
          2'd2:    held_d[23:16] = byte_i;
          default: held_d        = held_q;
        endcase
        idx_d = idx_q + 2'd1;
      end

      if (complete) begin
        if (cfg_i.rle_enable) begin
          rr_eff = (rr_q == 8'd0) ? 8'd1 : rr_q;
          if (rep_q) begin
            cnt  = rr_eff;
            rr_d = 8'd0;
          end else begin
            rr_d = rr_eff - 8'd1;
          end
          if (rr_d == 8'd0) begin
            hdr_d = 1'b1;
          end
        end
        emitted_sum        = emitted_q + CntW'(cnt);
        last               = (emitted_sum >= img_size);
        emitted_d          = emitted_sum;
        res_valid_o        = 1'b1;
        res_o.repeat_count = cnt;
        res_o.last_pixel   = last;
        if (last) begin
          hdr_d     = 1'b1;
          rep_d     = 1'b0;
          rr_d      = 8'd0;
          idx_d     = 2'd0;
          held_d    = '0;
          emitted_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q     <= 1'b1;
      rep_q     <= 1'b0;
      rr_q      <= 8'd0;
      idx_q     <= 2'd0;
      held_q    <= '0;
      emitted_q <= '0;
    end else if (restart_i) begin
      hdr_q     <= 1'b1;
      rep_q     <= 1'b0;
      rr_q      <= 8'd0;
      idx_q     <= 2'd0;
      held_q    <= '0;
      emitted_q <= '0;
    end else if (step_i) begin
      hdr_q     <= hdr_d;
      rep_q     <= rep_d;
      rr_q      <= rr_d;
      idx_q     <= idx_d;
      held_q    <= held_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tga_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_AFTER  = 700;
  localparam int SETTLE       = 6;

  typedef struct packed {
    bit         is_cfg;
    reg_idx_e   idx;
    logic [31:0] value;
    logic [7:0] data;
    bit         typed;
    pixel_t     want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tga_byte_if  byte_bus ();
  tga_pixel_if pixel_bus ();

  tga_rle_pixel_decoder DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .byte_i  (byte_bus),
    .pixel_o (pixel_bus)
  );

  always #4ns clk_i = ~clk_i;

  // Shadow of the registers and of the decode state.
  bit                 cfg_rle;
  logic [1:0]         cfg_fmt;
  logic [24:0]        cfg_count;
  bit                 hdr_pending;
  bit                 run_rep;
  longint unsigned    run_left;
  int                 comp_idx;
  logic [23:0]        held;
  longint unsigned    emitted;

  pixel_t             pending_pixels[$];
  int                 errors;
  int                 idle_cycles;
  int                 random_sent;
  bit                 quiet;
  bit                 hold_req;
  bit                 byte_typed;
  pixel_t             byte_want;

  function automatic void restart_stream();
    hdr_pending = 1'b1;
    run_rep     = 1'b0;
    run_left    = 0;
    comp_idx    = 0;
    held        = '0;
    emitted     = 0;
  endfunction

  function automatic longint unsigned image_size();
    longint unsigned n;
    n = longint'(cfg_count);
    if (n == 0) n = 1;
    if (n > (64'd1 << 24)) n = 64'd1 << 24;
    return n;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, output bit emits,
                                      output pixel_t px);
    logic [7:0]      r;
    logic [7:0]      g;
    logic [7:0]      bl;
    logic [7:0]      a;
    longint unsigned len;
    longint unsigned left;
    longint unsigned count;
    int              last_idx;
    bit              done;
    r = '0;
    g = '0;
    bl = '0;
    a = '0;
    count = 1;
    done = 1'b0;
    emits = 1'b0;
    px = '0;
    if (cfg_rle && cfg_fmt == FMT_GRAY) begin
      px.format_error = 1'b1;
      emits = 1'b1;
      return;
    end
    if (cfg_rle && hdr_pending) begin
      len = longint'(b[6:0]) + 1;
      left = (image_size() > emitted) ? image_size() - emitted : 1;
      if (len > left) len = left;
      run_rep = b[7];
      run_left = len;
      hdr_pending = 1'b0;
      comp_idx = 0;
      return;
    end
    if (cfg_fmt == FMT_GRAY) begin
      r = b;
      comp_idx = 0;
      done = 1'b1;
    end else begin
      last_idx = (cfg_fmt == FMT_BGR) ? 2 : 3;
      if (comp_idx >= last_idx) begin
        bl = held[7:0];
        g = held[15:8];
        if (cfg_fmt == FMT_BGR) begin
          r = b;
          a = ALPHA_OPAQUE;
        end else begin
          r = held[23:16];
          a = b;
        end
        comp_idx = 0;
        done = 1'b1;
      end else begin
        held[8*comp_idx +: 8] = b;
        comp_idx = (comp_idx + 1) % 4;
      end
    end
    if (!done) return;
    if (cfg_rle) begin
      if (run_left == 0) run_left = 1;
      if (run_rep) begin
        count = run_left;
        run_left = 0;
      end else begin
        count = 1;
        run_left = run_left - 1;
      end
      if (run_left == 0) hdr_pending = 1'b1;
    end
    emitted = emitted + count;
    px.red_or_gray  = r;
    px.green        = g;
    px.blue         = bl;
    px.alpha        = a;
    px.repeat_count = count[7:0];
    px.last_pixel   = (emitted >= image_size());
    emits = 1'b1;
    if (px.last_pixel) restart_stream();
  endfunction

  task automatic check_pixel(input pixel_t want, input pixel_t got);
    if (got.red_or_gray !== want.red_or_gray)
      $error("red_or_gray expected %0h actual %0h", want.red_or_gray, got.red_or_gray);
    if (got.green !== want.green)
      $error("green expected %0h actual %0h", want.green, got.green);
    if (got.blue !== want.blue)
      $error("blue expected %0h actual %0h", want.blue, got.blue);
    if (got.alpha !== want.alpha)
      $error("alpha expected %0h actual %0h", want.alpha, got.alpha);
    if (got.repeat_count !== want.repeat_count)
      $error("repeat_count expected %0d actual %0d", want.repeat_count, got.repeat_count);
    if (got.last_pixel !== want.last_pixel)
      $error("last_pixel expected %0b actual %0b", want.last_pixel, got.last_pixel);
    if (got.format_error !== want.format_error)
      $error("format_error expected %0b actual %0b", want.format_error, got.format_error);
    if (got !== want) errors++;
  endtask

  always @(posedge clk_i) begin : monitor_blk
    pixel_t got;
    pixel_t predicted;
    bit     emits;
    bit     busy;
    if (rst_ni) begin
      busy = 1'b0;
      if (pixel_bus.valid && pixel_bus.ready) begin
        busy = 1'b1;
        got = '{red_or_gray: pixel_bus.red_or_gray, green: pixel_bus.green,
                blue: pixel_bus.blue, alpha: pixel_bus.alpha,
                repeat_count: pixel_bus.repeat_count, last_pixel: pixel_bus.last_pixel,
                format_error: pixel_bus.format_error};
        if (pending_pixels.size() == 0) begin
          $error("pixel word with no expected pixel waiting");
          errors++;
        end else begin
          check_pixel(pending_pixels.pop_front(), got);
        end
      end
      if (byte_bus.valid && byte_bus.ready) begin
        busy = 1'b1;
        decode_byte(byte_bus.data_byte, emits, predicted);
        if (byte_typed) pending_pixels.push_back(byte_want);
        else if (emits) pending_pixels.push_back(predicted);
      end
      if (psel && penable) busy = 1'b1;
      idle_cycles = busy ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_ni);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("testbench: errors");
    $finish;
  end

  initial begin : receiver
    int n;
    pixel_bus.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        pixel_bus.ready <= 1'b0;
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        pixel_bus.ready <= 1'b0;
        n = $urandom_range(1, 16);
      end else begin
        pixel_bus.ready <= 1'b1;
        n = $urandom_range(1, 16);
      end
      repeat (n) @(negedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit typed, input pixel_t want);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      byte_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    byte_bus.valid     <= 1'b1;
    byte_bus.data_byte <= b;
    byte_typed         <= typed;
    byte_want          <= want;
    @(posedge clk_i);
    while (!byte_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    byte_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx) << 2;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_RLE_ENABLE:   cfg_rle = value[0];
      REG_PIXEL_FORMAT: cfg_fmt = value[1:0];
      default:          cfg_count = value[24:0];
    endcase
    restart_stream();
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_RLE_ENABLE:   readback = 32'(cfg_rle);
      REG_PIXEL_FORMAT: readback = 32'(cfg_fmt);
      default:          readback = 32'(cfg_count);
    endcase
    if (prdata !== readback) begin
      $error("prdata expected %0h actual %0h", readback, prdata);
      errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic stim_row_t cfg_row(input reg_idx_e idx, input logic [31:0] value);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.value = value;
    return row;
  endfunction

  function automatic stim_row_t byte_row(input logic [7:0] b);
    stim_row_t row;
    row = '0;
    row.data = b;
    return row;
  endfunction

  function automatic stim_row_t byte_row_exp(input logic [7:0] b, input pixel_t want);
    stim_row_t row;
    row = byte_row(b);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  task automatic random_phase(input bit hold);
    bit         rle;
    logic [1:0] fmt;
    logic [24:0] cnt;
    logic [7:0] hdr;
    int         sel;
    int         bpp;
    int         target;
    int         nb;
    int         pix;
    wait_idle();
    rle = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 9);
    if (sel < 3) fmt = FMT_GRAY;
    else if (sel < 6) fmt = FMT_BGR;
    else if (sel < 9) fmt = FMT_BGRA;
    else fmt = 2'd3;
    if (rle && fmt == FMT_GRAY && $urandom_range(0, 2) != 0) fmt = FMT_BGR;
    if (hold) begin
      rle = 1'b0;
      fmt = FMT_GRAY;
    end
    sel = $urandom_range(0, 19);
    if (sel == 0) cnt = '0;
    else if (sel == 1) cnt = {1'b1, 24'($urandom)};
    else if (sel == 2) cnt = 25'h100_0000;
    else if (sel < 5) cnt = 25'($urandom_range(41, 2000));
    else cnt = 25'($urandom_range(1, 40));
    if ($urandom_range(0, 1) == 0) begin
      cfg_write(REG_PIXEL_COUNT, 32'(cnt));
      cfg_write(REG_PIXEL_FORMAT, 32'(fmt));
      cfg_write(REG_RLE_ENABLE, 32'(rle));
    end else begin
      cfg_write(REG_RLE_ENABLE, 32'(rle));
      cfg_write(REG_PIXEL_FORMAT, 32'(fmt));
      cfg_write(REG_PIXEL_COUNT, 32'(cnt));
    end
    if (hold) hold_req = 1'b1;
    bpp = (fmt == FMT_GRAY) ? 1 : (fmt == FMT_BGR) ? 3 : 4;
    target = $urandom_range(30, 70);
    nb = 0;
    while (nb < target) begin
      if (rle && $urandom_range(0, 9) != 0) begin
        hdr = 8'($urandom);
        if (!hdr[7] && $urandom_range(0, 3) != 0) hdr[6:0] = 7'($urandom_range(0, 7));
        else if (!hdr[7]) hdr[6:0] = 7'($urandom_range(0, 15));
        send_byte(hdr, 1'b0, '0);
        nb++;
        pix = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
        repeat (pix * bpp) begin
          send_byte(8'($urandom), 1'b0, '0);
          nb++;
        end
      end else begin
        send_byte(8'($urandom), 1'b0, '0);
        nb++;
      end
    end
    random_sent += nb;
    if (random_sent >= QUIET_AFTER) quiet = 1'b1;
  endtask

  initial begin : stimulus
    stim_row_t dir_rows[$];
    int        phase;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_bus.valid = 1'b0;
    byte_bus.data_byte = '0;
    byte_typed = 1'b0;
    byte_want = '0;
    errors = 0;
    idle_cycles = 0;
    random_sent = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    cfg_rle = 1'b0;
    cfg_fmt = FMT_BGR;
    cfg_count = 25'd1;
    restart_stream();

    // Out of reset: one 24-bit pixel completes a one-pixel image.
    dir_rows.push_back(byte_row(8'h00));
    dir_rows.push_back(byte_row(8'h80));
    dir_rows.push_back(byte_row_exp(8'hFF, '{8'hFF, 8'h80, 8'h00, ALPHA_OPAQUE,
                                            8'd1, 1'b1, 1'b0}));
    dir_rows.push_back(cfg_row(REG_PIXEL_FORMAT, 32'(FMT_GRAY)));
    dir_rows.push_back(byte_row_exp(8'hFF, '{8'hFF, 8'h00, 8'h00, 8'h00, 8'd1, 1'b1, 1'b0}));
    dir_rows.push_back(byte_row_exp(8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 1'b1, 1'b0}));
    dir_rows.push_back(cfg_row(REG_PIXEL_FORMAT, 32'(FMT_BGRA)));
    dir_rows.push_back(byte_row(8'h11));
    dir_rows.push_back(byte_row(8'h22));
    dir_rows.push_back(byte_row(8'h33));
    dir_rows.push_back(byte_row_exp(8'h44, '{8'h33, 8'h22, 8'h11, 8'h44, 8'd1, 1'b1, 1'b0}));
    // Oversized pixel count with the spare format code.
    dir_rows.push_back(cfg_row(REG_PIXEL_COUNT, 32'h01FF_FFFF));
    dir_rows.push_back(cfg_row(REG_PIXEL_FORMAT, 32'd3));
    dir_rows.push_back(byte_row(8'hA5));
    dir_rows.push_back(byte_row(8'h5A));
    dir_rows.push_back(byte_row(8'hC3));
    dir_rows.push_back(byte_row(8'h3C));
    dir_rows.push_back(cfg_row(REG_PIXEL_COUNT, 32'h0100_0000));
    // Run-length packets with gray data are rejected byte by byte.
    dir_rows.push_back(cfg_row(REG_RLE_ENABLE, 32'd1));
    dir_rows.push_back(cfg_row(REG_PIXEL_FORMAT, 32'(FMT_GRAY)));
    dir_rows.push_back(byte_row_exp(8'h85, '{8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b1}));
    dir_rows.push_back(byte_row_exp(8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b1}));
    // A zero pixel count acts as one, so the longest repeat run is cut to one.
    dir_rows.push_back(cfg_row(REG_PIXEL_FORMAT, 32'(FMT_BGR)));
    dir_rows.push_back(cfg_row(REG_PIXEL_COUNT, 32'd0));
    dir_rows.push_back(byte_row(8'hFF));
    dir_rows.push_back(byte_row(8'h01));
    dir_rows.push_back(byte_row(8'h02));
    dir_rows.push_back(byte_row_exp(8'h03, '{8'h03, 8'h02, 8'h01, ALPHA_OPAQUE,
                                            8'd1, 1'b1, 1'b0}));
    // A raw run of six is cut to the two pixels of the image.
    dir_rows.push_back(cfg_row(REG_PIXEL_COUNT, 32'd2));
    dir_rows.push_back(byte_row(8'h05));
    dir_rows.push_back(byte_row(8'h10));
    dir_rows.push_back(byte_row(8'h20));
    dir_rows.push_back(byte_row(8'h30));
    dir_rows.push_back(byte_row(8'hEF));
    dir_rows.push_back(byte_row(8'hDF));
    dir_rows.push_back(byte_row(8'hCF));

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        cfg_write(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_byte(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      random_phase(phase == 2);
      phase++;
    end
    wait_idle();

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/tga_pkg.sv
hdl/tga_byte_if.sv
hdl/tga_pixel_if.sv
hdl/tga_apb_regs.sv
hdl/tga_decode.sv
hdl/tga_rle_pixel_decoder.sv
tb/testbench.sv
